// File: src/ctov_pkg.sv
// Shared types and constants for the CD table-of-contents offset validator.
package ctov_pkg;

   localparam int unsigned OffsetWidth = 32;
   localparam int unsigned IndexWidth  = 7;
   localparam int unsigned CodeWidth   = 4;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned CsrDatWidth = 24;

   // Verdict codes.
   localparam logic [CodeWidth-1:0] ErrOk         = 4'd0;
   localparam logic [CodeWidth-1:0] ErrLeadZero   = 4'd1;
   localparam logic [CodeWidth-1:0] ErrNoTracks   = 4'd2;
   localparam logic [CodeWidth-1:0] ErrTooMany    = 4'd3;
   localparam logic [CodeWidth-1:0] ErrAboveMax   = 4'd4;
   localparam logic [CodeWidth-1:0] ErrNegative   = 4'd5;
   localparam logic [CodeWidth-1:0] ErrMisordered = 4'd6;
   localparam logic [CodeWidth-1:0] ErrShort      = 4'd7;
   localparam logic [CodeWidth-1:0] ErrTooClose   = 4'd8;

   // Register indexes on the configuration port.
   localparam logic [CsrIdxWidth-1:0] CsrMaxBlockAddress   = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CsrMinTrackLength    = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CsrMinOffsetDistance = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CsrMaxTrackCount     = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CsrRequireLeadout    = 3'd4;

   // Track index reported with count errors, and the saturation point of the count.
   localparam logic [IndexWidth-1:0] CountErrorIndex = 7'd100;
   localparam logic [IndexWidth-1:0] CountSat        = 7'd127;

   typedef struct packed {
      logic signed [OffsetWidth-1:0] frame_offset;
      logic                          is_leadout;
   } req_type;

   typedef struct packed {
      logic [CodeWidth-1:0]          error_code;
      logic signed [OffsetWidth-1:0] bad_value;
      logic [IndexWidth-1:0]         bad_index;
   } rsp_type;

   typedef struct packed {
      logic [23:0]           addr_limit;
      logic [15:0]           min_track_length;
      logic [15:0]           min_offset_distance;
      logic [IndexWidth-1:0] max_track_count;
      logic                  require_leadout;
   } cfg_type;

endpackage

// File: src/ctov_check.sv
// Offset check of one table entry against its predecessor.
module ctov_check import ctov_pkg::*; (
   input  logic signed [OffsetWidth-1:0] curr,
   input  logic signed [OffsetWidth-1:0] prev,
   input  logic                          is_leadout,
   input  cfg_type                       cfg,
   output logic [CodeWidth-1:0]          code
);

   logic signed [OffsetWidth:0] curr_x;
   logic signed [OffsetWidth:0] prev_x;
   logic signed [OffsetWidth:0] max_x;
   logic signed [OffsetWidth:0] gap;
   logic                        curr_zero;

   assign curr_x    = {curr[OffsetWidth-1], curr};
   assign prev_x    = {prev[OffsetWidth-1], prev};
   assign max_x     = {{(OffsetWidth-23){1'b0}}, cfg.addr_limit};
   assign gap       = curr_x - prev_x;
   assign curr_zero = (curr == '0);

   // A zero offset counts as a zero gap, whatever came before it.
   always_comb begin
      if (curr_x > max_x) begin
         code = ErrAboveMax;
      end else if (curr[OffsetWidth-1]) begin
         code = ErrNegative;
      end else if (!curr_zero && gap[OffsetWidth]) begin
         code = ErrMisordered;
      end else if (curr_zero || gap == '0) begin
         code = is_leadout ? ErrOk : ErrMisordered;
      end else if (gap < $signed({{(OffsetWidth-15){1'b0}}, cfg.min_track_length})) begin
         code = ErrShort;
      end else if (gap < $signed({{(OffsetWidth-15){1'b0}}, cfg.min_offset_distance})) begin
         code = ErrTooClose;
      end else begin
         code = ErrOk;
      end
   end

endmodule

// File: src/cd_toc_offset_validator.sv
// Top level of the CD table-of-contents offset validator.
//
//   Channel  Direction  Handshake              Payload
//   req_     in         req_valid / req_ready  req_data  (frame_offset, is_leadout)
//   rsp_     out        rsp_valid / rsp_ready  rsp_data  (error_code, bad_value, bad_index)
//   csr_     in         csr_valid / csr_ready  csr_index, csr_wdata
//
// An accepted item is held in an input register, is checked there against the previous
// offset and the table state, and the state is updated as it leaves that register, so a
// new item can be taken every cycle while no leadout waits. A leadout loads the result
// register as it leaves the input register. Only a leadout that finds the result register
// full and not being read waits, holding req_ready low; a held track offset always moves
// on.
// Synchronous reset clears the table state and restores the register defaults.
module cd_toc_offset_validator import ctov_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [CsrDatWidth-1:0] csr_wdata
);

   // Configuration registers.
   cfg_type cfg_ff, cfg_in;

   // Input stage.
   req_type in_ff, in_in;
   logic    in_vld_ff, in_vld_in;

   // Table state: the previous offset, a saturating track count and the first fault.
   logic signed [OffsetWidth-1:0] prev_ff, prev_in;
   logic [IndexWidth-1:0]         cnt_ff, cnt_in;
   logic                          fault_seen_ff, fault_seen_in;
   logic [CodeWidth-1:0]          fault_code_ff, fault_code_in;
   logic signed [OffsetWidth-1:0] fault_value_ff, fault_value_in;
   logic [IndexWidth-1:0]         fault_index_ff, fault_index_in;

   // Result stage.
   rsp_type rsp_ff, rsp_in;
   logic    rsp_vld_ff, rsp_vld_in;

   logic                  adv;
   logic [CodeWidth-1:0]  chk_code;
   logic [IndexWidth-1:0] cnt_inc;
   logic [IndexWidth-1:0] note_index;
   logic                  note;

   // The held item moves on unless it is a leadout and the result register cannot take it.
   assign adv       = in_vld_ff && (!in_ff.is_leadout || !rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || adv;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   ctov_check u_check (
      .curr       (in_ff.frame_offset),
      .prev       (prev_ff),
      .is_leadout (in_ff.is_leadout),
      .cfg        (cfg_ff),
      .code       (chk_code)
   );

   assign cnt_inc    = (cnt_ff == CountSat) ? cnt_ff : cnt_ff + 7'd1;
   assign note_index = in_ff.is_leadout ? '0 : cnt_inc;
   // The first offset of a table is only stored; later ones record the first fault only.
   assign note       = (cnt_ff != '0) && (chk_code != ErrOk) && !fault_seen_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CsrMaxBlockAddress:   cfg_in.addr_limit          = csr_wdata;
            CsrMinTrackLength:    cfg_in.min_track_length    = csr_wdata[15:0];
            CsrMinOffsetDistance: cfg_in.min_offset_distance = csr_wdata[15:0];
            CsrMaxTrackCount:     cfg_in.max_track_count     = csr_wdata[IndexWidth-1:0];
            CsrRequireLeadout:    cfg_in.require_leadout     = csr_wdata[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      in_in     = in_ff;
      in_vld_in = in_vld_ff;
      if (req_ready) begin
         in_vld_in = req_valid;
         in_in     = req_data;
      end
   end

   always_comb begin
      prev_in        = prev_ff;
      cnt_in         = cnt_ff;
      fault_seen_in  = fault_seen_ff;
      fault_code_in  = fault_code_ff;
      fault_value_in = fault_value_ff;
      fault_index_in = fault_index_ff;
      rsp_in         = rsp_ff;
      rsp_vld_in     = rsp_vld_ff && !rsp_ready;

      if (adv) begin
         if (note) begin
            fault_seen_in  = 1'b1;
            fault_code_in  = chk_code;
            fault_value_in = in_ff.frame_offset;
            fault_index_in = note_index;
         end

         if (!in_ff.is_leadout) begin
            cnt_in  = (cnt_ff == '0) ? 7'd1 : cnt_inc;
            prev_in = in_ff.frame_offset;
         end else begin
            // Verdict, in priority order, taking any fault the leadout itself just raised.
            rsp_vld_in = 1'b1;
            if (cfg_ff.require_leadout && in_ff.frame_offset == '0) begin
               rsp_in.error_code = ErrLeadZero;
               rsp_in.bad_value  = '0;
               rsp_in.bad_index  = '0;
            end else if (cnt_ff == '0) begin
               rsp_in.error_code = ErrNoTracks;
               rsp_in.bad_value  = '0;
               rsp_in.bad_index  = CountErrorIndex;
            end else if (cnt_ff > cfg_ff.max_track_count) begin
               rsp_in.error_code = ErrTooMany;
               rsp_in.bad_value  = {{(OffsetWidth-IndexWidth){1'b0}}, cnt_ff};
               rsp_in.bad_index  = CountErrorIndex;
            end else if (fault_seen_in) begin
               rsp_in.error_code = fault_code_in;
               rsp_in.bad_value  = fault_value_in;
               rsp_in.bad_index  = fault_index_in;
            end else begin
               rsp_in.error_code = ErrOk;
               rsp_in.bad_value  = '0;
               rsp_in.bad_index  = '0;
            end

            // The table state is cleared for the next table.
            prev_in        = '0;
            cnt_in         = '0;
            fault_seen_in  = 1'b0;
            fault_code_in  = '0;
            fault_value_in = '0;
            fault_index_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         cfg_ff.addr_limit          <= 24'd449999;
         cfg_ff.min_track_length    <= 16'd150;
         cfg_ff.min_offset_distance <= 16'd300;
         cfg_ff.max_track_count     <= 7'd99;
         cfg_ff.require_leadout     <= 1'b0;
         in_vld_ff      <= 1'b0;
         rsp_vld_ff     <= 1'b0;
         prev_ff        <= '0;
         cnt_ff         <= '0;
         fault_seen_ff  <= 1'b0;
         fault_code_ff  <= '0;
         fault_value_ff <= '0;
         fault_index_ff <= '0;
      end else begin
         cfg_ff         <= cfg_in;
         in_vld_ff      <= in_vld_in;
         rsp_vld_ff     <= rsp_vld_in;
         prev_ff        <= prev_in;
         cnt_ff         <= cnt_in;
         fault_seen_ff  <= fault_seen_in;
         fault_code_ff  <= fault_code_in;
         fault_value_ff <= fault_value_in;
         fault_index_ff <= fault_index_in;
      end
   end

endmodule
